// ===== rtl/mpv_pkg.sv =====
// Shared constants and types for the modified PV pointwise block.
// No dependencies.
`timescale 1ns / 1ps

package mpv_pkg;

   localparam int DATA_W = 32;          // Q16.16 word width
   localparam int CSR_IDX_W = 3;        // eight config registers
   localparam int R_W = 23;             // h/420 for positive 31-bit h
   localparam int S_W = 20;             // sqrt(r * 2^16) for r below 2^23
   localparam int SQRT_STEPS = 24;      // bitwise square root steps

   // h/420 = (h >> 2) / 105, done as (h >> 2) * ceil(2^36 / 105) >> 36;
   // exact for every 29-bit quotient input.
   localparam int REF_SHIFT = 36;
   localparam logic [29:0] REF_RECIP = 30'd654471208;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EPV_SCALE    = 3'd0,
      CSR_EPV_OFFSET   = 3'd1,
      CSR_THETA_SCALE  = 3'd2,
      CSR_THETA_OFFSET = 3'd3,
      CSR_OUT_SCALE    = 3'd4,
      CSR_OUT_OFFSET   = 3'd5,
      CSR_EPV_FILL     = 3'd6,
      CSR_THETA_FILL   = 3'd7
   } csr_idx_type;

   localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [DATA_W-1:0] FILL_RST = 32'h8000_0000;

   // Per-point sideband that rides along the arithmetic pipeline.
   typedef struct packed {
      logic              ok;
      logic              sat;
      logic signed [31:0] e;
   } mpv_side_type;

endpackage

// ===== rtl/mpv_if.sv =====
// Valid/ready channel interfaces for request and response words.
// Depends on mpv_pkg.
`timescale 1ns / 1ps

interface mpv_req_if
   import mpv_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] epv_raw;
   logic signed [DATA_W-1:0] theta_raw;

   modport source (output valid, epv_raw, theta_raw, input ready);
   modport sink   (input valid, epv_raw, theta_raw, output ready);
endinterface

interface mpv_rsp_if
   import mpv_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] mpv_value;
   logic                     point_valid;
   logic                     saturated;

   modport source (output valid, mpv_value, point_valid, saturated, input ready);
   modport sink   (input valid, mpv_value, point_valid, saturated, output ready);
endinterface

// ===== rtl/mpv_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Standalone; carries an opaque sideband word alongside.
`timescale 1ns / 1ps

module mpv_div_pipe #(
   parameter int NW = 31,
   parameter int DW = 9,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_vld,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [PW-1:0] in_pay,
   output logic          out_vld,
   output logic [NW-1:0] out_quo,
   output logic [PW-1:0] out_pay
);

   logic          vld_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [DW-1:0] rem_ff [NW];
   logic [PW-1:0] pay_ff [NW];

   for (genvar g = 0; g < NW; g++) begin : g_stage
      localparam int B = NW - 1 - g;
      logic          vld_i;
      logic [NW-1:0] num_i, quo_i, quo_in;
      logic [DW-1:0] den_i, rem_i, rem_in;
      logic [PW-1:0] pay_i;
      logic [DW:0]   sh;
      logic          ge;

      if (g == 0) begin : g_first
         assign vld_i = in_vld;
         assign num_i = in_num;
         assign den_i = in_den;
         assign pay_i = in_pay;
         assign rem_i = '0;
         assign quo_i = '0;
      end else begin : g_next
         assign vld_i = vld_ff[g-1];
         assign num_i = num_ff[g-1];
         assign den_i = den_ff[g-1];
         assign pay_i = pay_ff[g-1];
         assign rem_i = rem_ff[g-1];
         assign quo_i = quo_ff[g-1];
      end

      always_comb begin
         sh = {rem_i, num_i[B]};
         ge = (sh >= {1'b0, den_i});
         rem_in = ge ? DW'(sh - {1'b0, den_i}) : DW'(sh);
         quo_in = quo_i;
         quo_in[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_i;
         end
         if (en) begin
            num_ff[g] <= num_i;
            den_ff[g] <= den_i;
            pay_ff[g] <= pay_i;
            rem_ff[g] <= rem_in;
            quo_ff[g] <= quo_in;
         end
      end
   end

   assign out_vld = vld_ff[NW-1];
   assign out_quo = quo_ff[NW-1];
   assign out_pay = pay_ff[NW-1];

endmodule

// ===== rtl/mpv_sqrt_pipe.sv =====
// Pipelined bitwise integer square root, one result bit per stage.
// Standalone; carries an opaque sideband word alongside.
`timescale 1ns / 1ps

module mpv_sqrt_pipe #(
   parameter int STEPS = 24,
   parameter int NW = 39,
   parameter int PW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  logic [NW-1:0]    in_n,
   input  logic [PW-1:0]    in_pay,
   output logic             out_vld,
   output logic [STEPS-1:0] out_res,
   output logic [PW-1:0]    out_pay
);

   localparam int SQ_W = 2 * STEPS;
   localparam int MW = (SQ_W > NW) ? SQ_W : NW;

   logic             vld_ff [STEPS];
   logic [NW-1:0]    n_ff   [STEPS];
   logic [STEPS-1:0] res_ff [STEPS];
   logic [PW-1:0]    pay_ff [STEPS];

   for (genvar g = 0; g < STEPS; g++) begin : g_stage
      localparam int B = STEPS - 1 - g;
      logic             vld_i;
      logic [NW-1:0]    n_i;
      logic [STEPS-1:0] res_i, t, res_in;
      logic [PW-1:0]    pay_i;
      logic [SQ_W-1:0]  sq;

      if (g == 0) begin : g_first
         assign vld_i = in_vld;
         assign n_i   = in_n;
         assign res_i = '0;
         assign pay_i = in_pay;
      end else begin : g_next
         assign vld_i = vld_ff[g-1];
         assign n_i   = n_ff[g-1];
         assign res_i = res_ff[g-1];
         assign pay_i = pay_ff[g-1];
      end

      always_comb begin
         t = res_i;
         t[B] = 1'b1;
         sq = {{STEPS{1'b0}}, t} * {{STEPS{1'b0}}, t};
         res_in = (MW'(sq) <= MW'(n_i)) ? t : res_i;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_i;
         end
         if (en) begin
            n_ff[g]   <= n_i;
            res_ff[g] <= res_in;
            pay_ff[g] <= pay_i;
         end
      end
   end

   assign out_vld = vld_ff[STEPS-1];
   assign out_res = res_ff[STEPS-1];
   assign out_pay = pay_ff[STEPS-1];

endmodule

// ===== rtl/modified_pv_pointwise_unit.sv =====
// Top level of the modified potential vorticity pointwise pipeline.
// Depends on mpv_pkg, mpv_if, mpv_div_pipe and mpv_sqrt_pipe.
// Throughput: one word per cycle when not stalled; h/420 is a registered
// reciprocal multiply, the two divider chains (33, 49 stages) and the 24-stage
// square root are fully pipelined, so nothing iterates.
// Backpressure stalls the whole pipeline in place as one enable.
// Reset (synchronous, active high) clears all valid bits and loads the
// config registers with their defaults; datapath registers are not reset.
`timescale 1ns / 1ps

module modified_pv_pointwise_unit
   import mpv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   mpv_req_if.sink              req_port,
   mpv_rsp_if.source            rsp_port,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_data
);

   localparam logic signed [64:0] MAX32 = 65'sd2147483647;
   localparam logic signed [64:0] MIN32 = -65'sd2147483648;

   // Saturate a wide signed value to 32 bits; bit 32 of the result is the flag.
   function automatic logic [32:0] clamp32(input logic signed [64:0] x);
      logic [32:0] r;
      if (x > MAX32) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (x < MIN32) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, x[31:0]};
      end
      return r;
   endfunction

   // ---------------- config registers ----------------
   logic [DATA_W-1:0] cfg_ff [8];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[CSR_EPV_SCALE]    <= ONE_Q16;
         cfg_ff[CSR_EPV_OFFSET]   <= '0;
         cfg_ff[CSR_THETA_SCALE]  <= ONE_Q16;
         cfg_ff[CSR_THETA_OFFSET] <= '0;
         cfg_ff[CSR_OUT_SCALE]    <= ONE_Q16;
         cfg_ff[CSR_OUT_OFFSET]   <= '0;
         cfg_ff[CSR_EPV_FILL]     <= FILL_RST;
         cfg_ff[CSR_THETA_FILL]   <= FILL_RST;
      end else if (csr_wr_en) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   logic signed [31:0] epv_scale, epv_off, th_scale, th_off, out_scale, out_off;
   logic signed [31:0] epv_fill, th_fill;
   assign epv_scale = $signed(cfg_ff[CSR_EPV_SCALE]);
   assign epv_off   = $signed(cfg_ff[CSR_EPV_OFFSET]);
   assign th_scale  = $signed(cfg_ff[CSR_THETA_SCALE]);
   assign th_off    = $signed(cfg_ff[CSR_THETA_OFFSET]);
   assign out_scale = $signed(cfg_ff[CSR_OUT_SCALE]);
   assign out_off   = $signed(cfg_ff[CSR_OUT_OFFSET]);
   assign epv_fill  = $signed(cfg_ff[CSR_EPV_FILL]);
   assign th_fill   = $signed(cfg_ff[CSR_THETA_FILL]);

   // Whole pipeline advances together; it holds only when the output word
   // is waiting and not taken.
   logic out_vld_ff;
   logic en;
   assign en = !out_vld_ff || rsp_port.ready;
   assign req_port.ready = en;

   logic acc;
   assign acc = req_port.valid && en;

   // ---------------- stage A: raw scaling products ----------------
   logic               a_vld_ff, a_ok_ff;
   logic signed [63:0] a_pe_ff, a_ph_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= acc;
      end
      if (en) begin
         a_pe_ff <= req_port.epv_raw * epv_scale;
         a_ph_ff <= req_port.theta_raw * th_scale;
         a_ok_ff <= !(req_port.epv_raw == epv_fill || req_port.theta_raw == th_fill
                      || req_port.theta_raw <= 32'sd0);
      end
   end

   // ---------------- stage B: offsets and clamps ----------------
   logic signed [64:0] e_sum, h_sum;
   logic [32:0]        e_cl, h_cl;
   logic               b_vld_ff;
   mpv_side_type       b_side_ff;
   logic [30:0]        b_h_ff;

   always_comb begin
      e_sum = (a_pe_ff >>> 16) + epv_off;
      h_sum = (a_ph_ff >>> 16) + th_off;
      e_cl = clamp32(e_sum);
      h_cl = clamp32(h_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
      if (en) begin
         b_side_ff.ok  <= a_ok_ff && !h_cl[31] && (h_cl[31:0] != '0) && (out_scale != '0);
         b_side_ff.sat <= e_cl[32] || h_cl[32];
         b_side_ff.e   <= $signed(e_cl[31:0]);
         b_h_ff        <= h_cl[31] ? 31'd0 : h_cl[30:0];
      end
   end

   // ---------------- r = h / 420 ----------------
   // 420 = 4 * 105: drop two bits, then multiply by the scaled reciprocal.
   logic           r_vld_ff;
   mpv_side_type   r_side_ff;
   logic [58:0]    r_prod_ff;
   logic           d1_vld;
   logic [R_W-1:0] d1_quo;
   mpv_side_type   d1_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (en) begin
         r_vld_ff <= b_vld_ff;
      end
      if (en) begin
         r_side_ff <= b_side_ff;
         r_prod_ff <= 59'(b_h_ff[30:2]) * 59'(REF_RECIP);
      end
   end

   assign d1_vld  = r_vld_ff;
   assign d1_quo  = r_prod_ff[REF_SHIFT+R_W-1:REF_SHIFT];
   assign d1_side = r_side_ff;

   // ---------------- s = sqrt(r * 2^16) ----------------
   logic                  sq_vld;
   logic [SQRT_STEPS-1:0] sq_res;
   logic [R_W+$bits(mpv_side_type)-1:0] sq_pay;

   mpv_sqrt_pipe #(.STEPS(SQRT_STEPS), .NW(R_W + 16), .PW(R_W + $bits(mpv_side_type)))
   u_sqrt (
      .clock, .reset, .en,
      .in_vld (d1_vld),
      .in_n   ({d1_quo[R_W-1:0], 16'h0000}),
      .in_pay ({d1_quo[R_W-1:0], d1_side}),
      .out_vld(sq_vld),
      .out_res(sq_res),
      .out_pay(sq_pay)
   );

   logic [R_W-1:0] sq_r;
   mpv_side_type   sq_side;
   assign sq_r    = sq_pay[R_W+$bits(mpv_side_type)-1:$bits(mpv_side_type)];
   assign sq_side = sq_pay[$bits(mpv_side_type)-1:0];

   // ---------------- stages C..F: r^4 * sqrt(r) ----------------
   logic         c_vld_ff, d_vld_ff, e_vld_ff, f_vld_ff;
   mpv_side_type c_side_ff, d_side_ff, e_side_ff, f_side_ff;
   logic [29:0]  c_r2_ff;
   logic [S_W-1:0] c_s_ff, d_s_ff;
   logic [43:0]  d_r4_ff;
   logic [51:0]  e_lo_ff;
   logic [31:0]  e_hi_ff;
   logic [47:0]  f_d_ff;
   logic         f_dsat_ff;

   logic [45:0]  rr;
   logic [59:0]  r2sq;
   logic [63:0]  dfull;
   always_comb begin
      rr    = 46'(sq_r) * 46'(sq_r);
      r2sq  = 60'(c_r2_ff) * 60'(c_r2_ff);
      dfull = 64'(e_lo_ff) + {e_hi_ff, 32'h0000_0000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
         f_vld_ff <= 1'b0;
      end else if (en) begin
         c_vld_ff <= sq_vld;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
         f_vld_ff <= e_vld_ff;
      end
      if (en) begin
         c_side_ff <= sq_side;
         c_r2_ff   <= rr[45:16];
         c_s_ff    <= sq_res[S_W-1:0];
         d_side_ff <= c_side_ff;
         d_r4_ff   <= r2sq[59:16];
         d_s_ff    <= c_s_ff;
         // 44x20 product split into two partial products
         e_side_ff <= d_side_ff;
         e_lo_ff   <= 52'(d_r4_ff[31:0]) * 52'(d_s_ff);
         e_hi_ff   <= 32'(d_r4_ff[43:32]) * 32'(d_s_ff);
         f_side_ff <= e_side_ff;
         f_d_ff    <= dfull[63:16];
         // d of 0, 1 or 2 puts 2^32/d past the positive range
         f_dsat_ff <= (dfull[63:16] <= 48'd2);
      end
   end

   // ---------------- p = 2^32 / d ----------------
   logic         d2_vld;
   logic [32:0]  d2_quo;
   logic [$bits(mpv_side_type):0] d2_pay;
   mpv_side_type f_side_adj;
   mpv_side_type g_side;
   logic         g_dsat;

   always_comb begin
      f_side_adj = f_side_ff;
      f_side_adj.sat = f_side_ff.sat || f_dsat_ff;
   end

   mpv_div_pipe #(.NW(33), .DW(48), .PW($bits(mpv_side_type) + 1)) u_div_recip (
      .clock, .reset, .en,
      .in_vld (f_vld_ff),
      .in_num (33'h1_0000_0000),
      .in_den (f_d_ff),
      .in_pay ({f_dsat_ff, f_side_adj}),
      .out_vld(d2_vld),
      .out_quo(d2_quo),
      .out_pay(d2_pay)
   );

   assign g_dsat = d2_pay[$bits(mpv_side_type)];
   assign g_side = d2_pay[$bits(mpv_side_type)-1:0];

   // ---------------- stages G..I: e*p, clamp, output prescale ----------------
   logic [30:0]        p;
   logic               g_vld_ff, h_vld_ff, i_vld_ff;
   mpv_side_type       g_side_ff, h_side_ff;
   mpv_side_type       g_side_adj;
   logic signed [63:0] g_prod_ff;
   logic signed [31:0] h_m_ff;
   logic [32:0]        m_cl;
   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic [31:0]        dmag;
   logic               i_ok_ff, i_sat_ff, i_neg_ff;
   logic [48:0]        i_num_ff;
   logic [31:0]        i_den_ff;

   always_comb begin
      p    = g_dsat ? 31'h7FFF_FFFF : d2_quo[30:0];
      m_cl = clamp32(65'(g_prod_ff >>> 16));
      g_side_adj = g_side_ff;
      g_side_adj.sat = g_side_ff.sat || m_cl[32];
      diff = 33'(h_m_ff) - 33'(out_off);
      mag  = diff[32] ? 33'(-diff) : 33'(diff);
      dmag = out_scale[31] ? 32'(-out_scale) : 32'(out_scale);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
         i_vld_ff <= 1'b0;
      end else if (en) begin
         g_vld_ff <= d2_vld;
         h_vld_ff <= g_vld_ff;
         i_vld_ff <= h_vld_ff;
      end
      if (en) begin
         g_side_ff     <= g_side;
         g_prod_ff     <= g_side.e * $signed({1'b0, p});
         h_side_ff     <= g_side_adj;
         h_m_ff        <= $signed(m_cl[31:0]);
         i_ok_ff       <= h_side_ff.ok;
         i_sat_ff      <= h_side_ff.sat;
         i_neg_ff      <= diff[32] ^ out_scale[31];
         i_num_ff      <= {mag, 16'h0000};
         i_den_ff      <= dmag;
      end
   end

   // ---------------- q = (m - off) * 2^16 / out_scale ----------------
   logic        d3_vld;
   logic [48:0] d3_quo;
   logic [2:0]  d3_pay;

   mpv_div_pipe #(.NW(49), .DW(32), .PW(3)) u_div_out (
      .clock, .reset, .en,
      .in_vld (i_vld_ff),
      .in_num (i_num_ff),
      .in_den (i_den_ff),
      .in_pay ({i_neg_ff, i_ok_ff, i_sat_ff}),
      .out_vld(d3_vld),
      .out_quo(d3_quo),
      .out_pay(d3_pay)
   );

   // ---------------- output register ----------------
   logic        q_neg, q_ok, q_sat, q_ovf;
   logic [31:0] q_val;
   logic [31:0] out_val_ff;
   logic        out_pv_ff, out_sat_ff;

   always_comb begin
      q_neg = d3_pay[2];
      q_ok  = d3_pay[1];
      q_sat = d3_pay[0];
      if (q_neg) begin
         q_ovf = (d3_quo > 49'h0_8000_0000);
         q_val = q_ovf ? 32'h8000_0000 : 32'(-d3_quo);
      end else begin
         q_ovf = (d3_quo > 49'h0_7FFF_FFFF);
         q_val = q_ovf ? 32'h7FFF_FFFF : d3_quo[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= d3_vld;
      end
      if (en) begin
         out_val_ff <= q_ok ? q_val : epv_fill;
         out_pv_ff  <= q_ok;
         out_sat_ff <= q_ok && (q_sat || q_ovf);
      end
   end

   assign rsp_port.valid       = out_vld_ff;
   assign rsp_port.mpv_value   = $signed(out_val_ff);
   assign rsp_port.point_valid = out_pv_ff;
   assign rsp_port.saturated   = out_sat_ff;

   // ---------------- assertions ----------------
   a_reset_empty: assert property (@(posedge clock) reset |=> !out_vld_ff)
      else $error("output valid after reset");

   a_fill_word: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !out_pv_ff) |-> (out_val_ff == epv_fill && !out_sat_ff))
      else $error("fill word carries wrong value or saturation");

   a_sat_needs_valid: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_sat_ff) |-> out_pv_ff)
      else $error("saturation flagged on a fill word");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> ($stable(f_d_ff) && $stable(f_vld_ff) && $stable(i_num_ff)))
      else $error("pipeline moved during stall");

endmodule

// ===== tb/modified_pv_pointwise_unit_test.sv =====
// Self-checking bench for modified_pv_pointwise_unit: random and corner grid points,
// several register settings, a bit-exact built-in predictor and in-order compare.
// Depends on mpv_pkg, mpv_if and the RTL of the block.
`timescale 1ns / 1ps

module modified_pv_pointwise_unit_test;
   import mpv_pkg::*;

   localparam int LATENCY    = 117;
   localparam int WATCHDOG   = 4000;   // long hold + full pipe + gaps, several times
   localparam int LONG_HOLD  = 400;

   typedef struct {
      logic signed [31:0] epv;
      logic signed [31:0] th;
   } point_type;

   typedef struct {
      logic signed [31:0] value;
      logic               pv;
      logic               sat;
   } mpv_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_data  = '0;

   mpv_req_if req_ch();
   mpv_rsp_if rsp_ch();

   modified_pv_pointwise_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_ch.sink),
      .rsp_port  (rsp_ch.source),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the register file, indexed by csr_idx_type
   logic signed [31:0] csr_shadow [8];

   point_type    pending_points[$];
   mpv_word_type mpv_expected[$];

   int errors = 0;
   int idle_cycles = 0;
   int hold_requests = 0;
   int hold_served = 0;
   bit src_bursty = 1'b0;    // 1: no gaps between words
   bit snk_bursty = 1'b0;    // 1: ready held high

   initial begin
      req_ch.valid = 1'b0;
      req_ch.epv_raw = '0;
      req_ch.theta_raw = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic longint clamp_word(longint x, inout bit sat);
      if (x > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return x;
   endfunction

   // e * (h/420)^-4.5, done as 1/(r^4 * sqrt r) in Q16.16
   function automatic mpv_word_type mpv_of_point(logic signed [31:0] epv,
                                                 logic signed [31:0] th);
      mpv_word_type w;
      bit sat;
      longint e, h, m, q;
      logic [63:0] r, r2, r4, s, d, p, t;
      w.value = csr_shadow[CSR_EPV_FILL];
      w.pv = 1'b0;
      w.sat = 1'b0;
      sat = 1'b0;
      if (epv == csr_shadow[CSR_EPV_FILL] || th == csr_shadow[CSR_THETA_FILL] || th <= 0)
         return w;
      e = clamp_word(((longint'(epv) * longint'(csr_shadow[CSR_EPV_SCALE])) >>> 16)
                     + longint'(csr_shadow[CSR_EPV_OFFSET]), sat);
      h = clamp_word(((longint'(th) * longint'(csr_shadow[CSR_THETA_SCALE])) >>> 16)
                     + longint'(csr_shadow[CSR_THETA_OFFSET]), sat);
      if (h <= 0 || csr_shadow[CSR_OUT_SCALE] == 0)
         return w;
      r  = 64'(h) / 64'd420;
      r2 = (r * r) >> 16;
      r4 = (r2 * r2) >> 16;
      s  = '0;
      for (int i = 23; i >= 0; i--) begin
         t = s | (64'd1 << i);
         if (t * t <= (r << 16))
            s = t;
      end
      d = (r4 * s) >> 16;
      if (d == 0) begin
         p = 64'h7FFF_FFFF;
         sat = 1'b1;
      end else begin
         p = 64'h1_0000_0000 / d;
         if (p > 64'h7FFF_FFFF) begin
            p = 64'h7FFF_FFFF;
            sat = 1'b1;
         end
      end
      m = clamp_word((e * longint'(p)) >>> 16, sat);
      q = clamp_word(((m - longint'(csr_shadow[CSR_OUT_OFFSET])) * 64'sd65536)
                     / longint'(csr_shadow[CSR_OUT_SCALE]), sat);
      w.value = q[31:0];
      w.pv = 1'b1;
      w.sat = sat;
      return w;
   endfunction

   // Driver: one word per slot, random gap after each, predicts on accept.
   int src_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            mpv_expected.push_back(mpv_of_point(req_ch.epv_raw, req_ch.theta_raw));
         if (!req_ch.valid || req_ch.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_points.size() > 0) begin
               point_type pt;
               pt = pending_points.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.epv_raw <= pt.epv;
               req_ch.theta_raw <= pt.th;
               src_gap = src_bursty ? 0 : $urandom_range(0, 15);
               if ($urandom_range(0, 63) == 0)
                  src_bursty = !src_bursty;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: random ready stalls, one long hold on request, compare on accept.
   int snk_hold = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         snk_hold = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (mpv_expected.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected word: value %h valid %b sat %b",
                           rsp_ch.mpv_value, rsp_ch.point_valid, rsp_ch.saturated);
            end else begin
               mpv_word_type x;
               x = mpv_expected.pop_front();
               if (rsp_ch.mpv_value !== x.value || rsp_ch.point_valid !== x.pv
                   || rsp_ch.saturated !== x.sat) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp %h/%b/%b got %h/%b/%b",
                              x.value, x.pv, x.sat, rsp_ch.mpv_value,
                              rsp_ch.point_valid, rsp_ch.saturated);
               end
            end
            snk_hold = snk_bursty ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 63) == 0)
               snk_bursty = !snk_bursty;
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            snk_hold = LONG_HOLD;
         end
         rsp_ch.ready <= (snk_hold == 0);
         if (snk_hold > 0)
            snk_hold--;
      end
   end

   // Watchdog: no word moving on either side for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || reset)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("modified_pv_pointwise_unit_test: done, errors");
         $finish;
      end
   end

   task automatic reg_defaults();
      csr_shadow[CSR_EPV_SCALE]    = ONE_Q16;
      csr_shadow[CSR_EPV_OFFSET]   = '0;
      csr_shadow[CSR_THETA_SCALE]  = ONE_Q16;
      csr_shadow[CSR_THETA_OFFSET] = '0;
      csr_shadow[CSR_OUT_SCALE]    = ONE_Q16;
      csr_shadow[CSR_OUT_OFFSET]   = '0;
      csr_shadow[CSR_EPV_FILL]     = FILL_RST;
      csr_shadow[CSR_THETA_FILL]   = FILL_RST;
   endtask

   // Loads all eight registers back to back; only called with the pipe empty.
   task automatic load_regs(input logic [31:0] v [8]);
      for (int i = 0; i < 8; i++) begin
         @(posedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= csr_idx_type'(i);
         csr_data  <= v[i];
         csr_shadow[i] = v[i];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic point_type rand_point();
      point_type pt;
      pt.epv = $signed($urandom_range(0, 32'hFFFF) - 32'sd32768) <<< $urandom_range(0, 12);
      case ($urandom_range(0, 11))
         0: pt.th = csr_shadow[CSR_THETA_FILL];
         1: pt.th = -$signed($urandom_range(0, 32'h7FFF_FFFF));
         2: pt.th = $urandom_range(1, 4000);                   // tiny temperature
         3: pt.th = $urandom_range(1, 32'h7FFF_FFFF);
         4: pt.th = $urandom();
         default: pt.th = $urandom_range(150 << 16, 2000 << 16);  // physical range
      endcase
      case ($urandom_range(0, 9))
         0: pt.epv = csr_shadow[CSR_EPV_FILL];
         1: pt.epv = $urandom();
         2: pt.epv = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: ;
      endcase
      return pt;
   endfunction

   task automatic run_points(input int n);
      for (int i = 0; i < n; i++)
         pending_points.push_back(rand_point());
      while (pending_points.size() != 0 || mpv_expected.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic point_type pt_of(logic signed [31:0] e, logic signed [31:0] t);
      point_type pt;
      pt.epv = e;
      pt.th = t;
      return pt;
   endfunction

   initial begin
      logic [31:0] regs [8];
      reg_defaults();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fills, non-positive theta, extremes, tiny theta, typical values
      pending_points.push_back(pt_of(32'sh8000_0000, 32'sd300 << 16));
      pending_points.push_back(pt_of(32'sh0001_0000, 32'sh8000_0000));
      pending_points.push_back(pt_of(32'sh0001_0000, 32'sd0));
      pending_points.push_back(pt_of(32'sh0001_0000, -32'sd1));
      pending_points.push_back(pt_of(32'sh0001_0000, 32'sd1));
      pending_points.push_back(pt_of(32'sh0001_0000, 32'sd420 << 16));
      pending_points.push_back(pt_of(32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
      pending_points.push_back(pt_of(32'sh8000_0001, 32'sh7FFF_FFFF));
      pending_points.push_back(pt_of(32'sh7FFF_FFFF, 32'sd1 << 16));
      pending_points.push_back(pt_of(-32'sd1, 32'sd100 << 16));
      pending_points.push_back(pt_of(32'sd0, 32'sd350 << 16));
      pending_points.push_back(pt_of(32'sh0000_0100, 32'sd800 << 16));
      pending_points.push_back(pt_of(32'shFFFF_0000, 32'sd420));
      hold_requests++;   // long receiver hold while the sender keeps pushing
      run_points(120);

      // extremes on every scale and offset but the theta scale, fills moved
      regs = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, ONE_Q16, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF};
      load_regs(regs);
      run_points(80);

      regs = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'h012C_0000};
      load_regs(regs);
      run_points(60);

      // output scale zero: every computed point falls back to fill
      regs = '{ONE_Q16, 32'h0, ONE_Q16, 32'h0, 32'h0, 32'h0, FILL_RST, FILL_RST};
      load_regs(regs);
      run_points(40);

      // realistic unit conversion
      regs = '{32'h0000_0100, 32'h0000_0010, 32'h0000_8000, 32'h0064_0000,
               32'h0000_0100, 32'hFFFF_F000, 32'h0000_1234, 32'h0000_0000};
      load_regs(regs);
      run_points(80);

      // random settings, the first pass with bounded scales and theta offset
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 8; i++)
            regs[i] = $urandom();
         if (k == 0) begin
            regs[CSR_EPV_SCALE] = $urandom_range(1, 32'h0004_0000);
            regs[CSR_THETA_SCALE] = $urandom_range(1, 32'h0004_0000);
            regs[CSR_THETA_OFFSET] = $urandom_range(0, 32'h0100_0000);
         end
         load_regs(regs);
         run_points(40);
      end

      if (errors == 0)
         $display("modified_pv_pointwise_unit_test: done, clean");
      else
         $display("modified_pv_pointwise_unit_test: done, errors");
      $finish;
   end

endmodule
